// ===== rtl/core/hrlc_pkg.sv =====
package hrlc_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_message;
    } req_in_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] file_byte;
        logic [2:0] method_code;
        logic [1:0] service_code;
        logic       last_result;
    } req_out_t;

    localparam logic [7:0] CHAR_NL = 8'h0A;
    localparam logic [7:0] CHAR_SP = 8'h20;
    localparam logic [7:0] CHAR_SL = 8'h2F;

    localparam logic KIND_FILE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [2:0] METH_GET = 3'd0;

    localparam logic [1:0] SVC_INVALID = 2'd0;
    localparam logic [1:0] SVC_ECHO    = 2'd1;
    localparam logic [1:0] SVC_STATIC  = 2'd2;

    localparam int NUM_METH = 7;
    localparam int NUM_SVC  = 2;

    localparam logic [7:0] METH_TEXT [0:6][0:6] = '{
        '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h45, 8'h41, 8'h44, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h55, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h54, 8'h52, 8'h41, 8'h43, 8'h45, 8'h00, 8'h00},
        '{8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43, 8'h54},
        '{8'h4F, 8'h50, 8'h54, 8'h49, 8'h4F, 8'h4E, 8'h00}
    };
    localparam logic [3:0] METH_LEN [0:6] = '{4'd3, 4'd4, 4'd4, 4'd3, 4'd5, 4'd7, 4'd6};

    localparam logic [7:0] SVC_TEXT [0:1][0:5] = '{
        '{8'h45, 8'h43, 8'h48, 8'h4F, 8'h00, 8'h00},
        '{8'h53, 8'h54, 8'h41, 8'h54, 8'h49, 8'h43}
    };
    localparam logic [2:0] SVC_LEN [0:1] = '{3'd4, 3'd6};

    function automatic logic [7:0] upcase(input logic [7:0] b);
        upcase = (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
    endfunction

endpackage

// ===== rtl/core/http_request_line_classifier_unit.sv =====
// A byte accepted into the input register is parsed from there once the result queue
// has room, and its result words are written into the queue, which offers them on out_data.
// Throughput: one byte per cycle unless the parse stage is held, which it is while the
// four-entry result queue lacks room for two words; the output moves one word per cycle.
// Reset (rst_n low, asynchronous) clears the parse state, the held summary and the queue.
module http_request_line_classifier_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hrlc_pkg::req_in_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hrlc_pkg::req_out_t out_data
);

    typedef enum logic [2:0] {
        SEC_METHOD  = 3'b001,
        SEC_URL     = 3'b010,
        SEC_VERSION = 3'b100
    } sec_t;

    typedef enum logic [3:0] {
        PH_BEFORE  = 4'b0001,
        PH_SEGMENT = 4'b0010,
        PH_FILE    = 4'b0100,
        PH_AFTER   = 4'b1000
    } phase_t;

    // Input register.
    logic              s1_valid_reg;
    hrlc_pkg::req_in_t s1_data_reg;

    // Parse state.
    sec_t       sec_reg, sec_next;
    logic       fin_reg, fin_next;
    logic [6:0] mcand_reg, mcand_next;
    logic [3:0] mlen_reg, mlen_next;
    phase_t     phase_reg, phase_next;
    logic [1:0] scand_reg, scand_next;
    logic [2:0] slen_reg, slen_next;
    logic       slash_reg, slash_next;
    logic       owed_reg, owed_next;
    logic [2:0] owed_meth_reg, owed_meth_next;
    logic [1:0] owed_svc_reg, owed_svc_next;

    // Result queue.
    hrlc_pkg::req_out_t fifo_reg [0:3];
    logic [1:0]         rptr_reg;
    logic [1:0]         wptr_reg;
    logic [2:0]         count_reg;

    logic               proc;
    logic               pop;
    logic [1:0]         nwr;
    hrlc_pkg::req_out_t wr0;
    hrlc_pkg::req_out_t wr1;

    hrlc_pkg::req_out_t loc [0:2];
    logic [1:0]         nloc;
    hrlc_pkg::req_out_t cl0, cl1, cl2;
    logic [2:0]         cnt;
    logic [7:0]         b;
    logic [7:0]         up;
    logic               eom;

    function automatic logic [2:0] meth_code(input logic [6:0] cand, input logic [3:0] len);
        logic [2:0] code;
        code = hrlc_pkg::METH_GET;
        for (int k = hrlc_pkg::NUM_METH - 1; k >= 0; k--)
        begin
            if (cand[k] && len == hrlc_pkg::METH_LEN[k])
            begin
                code = 3'(k);
            end
        end
        return code;
    endfunction

    function automatic logic [1:0] svc_code(input phase_t ph, input logic [1:0] cand,
                                            input logic [2:0] len);
        logic [1:0] code;
        code = hrlc_pkg::SVC_INVALID;
        if (ph != PH_BEFORE)
        begin
            if (cand[0] && len == hrlc_pkg::SVC_LEN[0])
            begin
                code = hrlc_pkg::SVC_ECHO;
            end
            else if (cand[1] && len == hrlc_pkg::SVC_LEN[1])
            begin
                code = hrlc_pkg::SVC_STATIC;
            end
        end
        return code;
    endfunction

    function automatic hrlc_pkg::req_out_t file_word(input logic [7:0] fb);
        hrlc_pkg::req_out_t w;
        w.result_kind  = hrlc_pkg::KIND_FILE;
        w.file_byte    = fb;
        w.method_code  = hrlc_pkg::METH_GET;
        w.service_code = hrlc_pkg::SVC_INVALID;
        w.last_result  = 1'b0;
        return w;
    endfunction

    function automatic hrlc_pkg::req_out_t summary_word(input logic [2:0] m,
                                                        input logic [1:0] s);
        hrlc_pkg::req_out_t w;
        w.result_kind  = hrlc_pkg::KIND_SUMMARY;
        w.file_byte    = 8'h00;
        w.method_code  = m;
        w.service_code = s;
        w.last_result  = 1'b1;
        return w;
    endfunction

    // The parse stage runs only when the queue has room for the two words a byte can add.
    assign proc      = s1_valid_reg && (count_reg <= 3'd2);
    assign in_ready  = !s1_valid_reg || proc;
    assign out_valid = (count_reg != 3'd0);
    assign out_data  = fifo_reg[rptr_reg];
    assign pop       = out_valid && out_ready;

    assign b   = s1_data_reg.in_byte;
    assign eom = s1_data_reg.end_of_message;
    assign up  = hrlc_pkg::upcase(b);

    always_comb
    begin
        sec_next   = sec_reg;
        fin_next   = fin_reg;
        mcand_next = mcand_reg;
        mlen_next  = mlen_reg;
        phase_next = phase_reg;
        scand_next = scand_reg;
        slen_next  = slen_reg;
        slash_next = slash_reg;
        nloc       = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            loc[i] = '0;
        end

        if (!fin_reg)
        begin
            if (b == hrlc_pkg::CHAR_NL)
            begin
                fin_next = 1'b1;
            end
            else if (b == hrlc_pkg::CHAR_SP)
            begin
                case (sec_reg)
                    SEC_METHOD: sec_next = SEC_URL;
                    SEC_URL:    sec_next = SEC_VERSION;
                    default:    sec_next = sec_reg;
                endcase
            end
            else if (sec_reg == SEC_METHOD)
            begin
                for (int k = 0; k < hrlc_pkg::NUM_METH; k++)
                begin
                    if (!(mlen_reg < hrlc_pkg::METH_LEN[k]
                          && hrlc_pkg::METH_TEXT[k][mlen_reg[2:0]] == up))
                    begin
                        mcand_next[k] = 1'b0;
                    end
                end
                if (mlen_reg != 4'd15)
                begin
                    mlen_next = mlen_reg + 4'd1;
                end
            end
            else if (sec_reg == SEC_URL)
            begin
                case (phase_reg)
                    PH_BEFORE:
                    begin
                        phase_next = PH_SEGMENT;
                    end
                    PH_SEGMENT:
                    begin
                        if (b == hrlc_pkg::CHAR_SL)
                        begin
                            phase_next = (svc_code(phase_reg, scand_reg, slen_reg)
                                          == hrlc_pkg::SVC_STATIC) ? PH_FILE : PH_AFTER;
                        end
                        else
                        begin
                            for (int k = 0; k < hrlc_pkg::NUM_SVC; k++)
                            begin
                                if (!(slen_reg < hrlc_pkg::SVC_LEN[k]
                                      && hrlc_pkg::SVC_TEXT[k][slen_reg] == up))
                                begin
                                    scand_next[k] = 1'b0;
                                end
                            end
                            if (slen_reg != 3'd7)
                            begin
                                slen_next = slen_reg + 3'd1;
                            end
                        end
                    end
                    PH_FILE:
                    begin
                        // A held slash is released by any later byte but a space or newline; a new slash is held.
                        if (slash_reg)
                        begin
                            loc[nloc] = file_word(hrlc_pkg::CHAR_SL);
                            nloc      = nloc + 2'd1;
                        end
                        if (b == hrlc_pkg::CHAR_SL)
                        begin
                            slash_next = 1'b1;
                        end
                        else
                        begin
                            slash_next = 1'b0;
                            loc[nloc]  = file_word(b);
                            nloc       = nloc + 2'd1;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end

            if (eom)
            begin
                fin_next = 1'b1;
            end
            if (fin_next)
            begin
                loc[nloc] = summary_word(meth_code(mcand_next, mlen_next),
                                         svc_code(phase_next, scand_next, slen_next));
                nloc      = nloc + 2'd1;
            end
        end

        if (eom)
        begin
            sec_next   = SEC_METHOD;
            fin_next   = 1'b0;
            mcand_next = 7'h7F;
            mlen_next  = 4'd0;
            phase_next = PH_BEFORE;
            scand_next = 2'b11;
            slen_next  = 3'd0;
            slash_next = 1'b0;
        end
    end

    // A summary held from the previous byte goes out ahead of this byte's words; at most
    // two words leave per byte and a third one, always a summary, is held for the next.
    always_comb
    begin
        if (owed_reg)
        begin
            cl0 = summary_word(owed_meth_reg, owed_svc_reg);
            cl1 = loc[0];
            cl2 = loc[1];
            cnt = {1'b0, nloc} + 3'd1;
        end
        else
        begin
            cl0 = loc[0];
            cl1 = loc[1];
            cl2 = loc[2];
            cnt = {1'b0, nloc};
        end
        wr0 = cl0;
        wr1 = cl1;
        nwr = (cnt > 3'd2) ? 2'd2 : cnt[1:0];
        if (cnt == 3'd3)
        begin
            owed_next      = 1'b1;
            owed_meth_next = cl2.method_code;
            owed_svc_next  = cl2.service_code;
        end
        else
        begin
            owed_next      = 1'b0;
            owed_meth_next = owed_meth_reg;
            owed_svc_next  = owed_svc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            sec_reg       <= SEC_METHOD;
            fin_reg       <= 1'b0;
            mcand_reg     <= 7'h7F;
            mlen_reg      <= 4'd0;
            phase_reg     <= PH_BEFORE;
            scand_reg     <= 2'b11;
            slen_reg      <= 3'd0;
            slash_reg     <= 1'b0;
            owed_reg      <= 1'b0;
            owed_meth_reg <= hrlc_pkg::METH_GET;
            owed_svc_reg  <= hrlc_pkg::SVC_INVALID;
            rptr_reg      <= 2'd0;
            wptr_reg      <= 2'd0;
            count_reg     <= 3'd0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (proc)
            begin
                sec_reg       <= sec_next;
                fin_reg       <= fin_next;
                mcand_reg     <= mcand_next;
                mlen_reg      <= mlen_next;
                phase_reg     <= phase_next;
                scand_reg     <= scand_next;
                slen_reg      <= slen_next;
                slash_reg     <= slash_next;
                owed_reg      <= owed_next;
                owed_meth_reg <= owed_meth_next;
                owed_svc_reg  <= owed_svc_next;
                wptr_reg      <= wptr_reg + nwr;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 2'd1;
            end
            count_reg <= count_reg + (proc ? {1'b0, nwr} : 3'd0) - {2'b00, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
        if (proc && nwr != 2'd0)
        begin
            fifo_reg[wptr_reg] <= wr0;
        end
        if (proc && nwr == 2'd2)
        begin
            fifo_reg[wptr_reg + 2'd1] <= wr1;
        end
    end

endmodule
